// File: src/hid_six_key_report_builder_core_assert.svh
// Assertion macros for the report builder checker.
`ifndef HID_SIX_KEY_REPORT_BUILDER_CORE_ASSERT_SVH
`define HID_SIX_KEY_REPORT_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HSK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/hsk_pkg.sv
// Shared types and constants for the six-key HID report builder.
`default_nettype none
package hsk_pkg;

  localparam int NUM_SLOTS  = 6;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] op_t;

  localparam kind_t KIND_REPORT   = 2'd0;
  localparam kind_t KIND_VOL_UP   = 2'd1;
  localparam kind_t KIND_VOL_DOWN = 2'd2;
  localparam kind_t KIND_MUTE     = 2'd3;

  localparam op_t OP_VOLUME  = 2'd0;
  localparam op_t OP_MUTE    = 2'd1;
  localparam op_t OP_PRESS   = 2'd2;
  localparam op_t OP_RELEASE = 2'd3;

  // Modifier usage codes 0xE0..0xE7 share this upper five-bit prefix.
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  typedef struct packed {
    logic load;   // capture a new word
    logic apply;  // update the report state
    logic step;   // one result goes out, count down
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
  } dp_status_t;

endpackage
`default_nettype wire

// File: src/hsk_ctrl.sv
// Controller state machine for the six-key HID report builder.
`default_nettype none
module hsk_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  hsk_pkg::dp_status_t status,
  output hsk_pkg::ctrl_cmd_t  cmd_out,
  output logic               busy,
  output logic               strobe
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_APPLY = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd_out       = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_out.load = 1'b1;
          state_next   = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_out.apply = 1'b1;
        // a zero volume change has nothing to send
        state_next = status.cnt_zero ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        cmd_out.step = 1'b1;
        if (status.cnt_one) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign strobe = (state == S_EMIT);

endmodule
`default_nettype wire

// File: src/hsk_dp.sv
// Datapath for the six-key HID report builder: report state, step counter, result fields.
`default_nettype none
module hsk_dp #(
  parameter int MAX_STEPS = 63,
  parameter int CNT_W     = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hsk_pkg::ctrl_cmd_t      cmd_in,
  input  logic [1:0]             cmd,
  input  logic [7:0]             key_code,
  input  logic signed [6:0]      volume_delta,
  output hsk_pkg::dp_status_t     status,
  output logic [1:0]             kind,
  output logic [7:0]             modifier_bits,
  output logic [7:0]             slot_zero,
  output logic [7:0]             slot_one,
  output logic [7:0]             slot_two,
  output logic [7:0]             slot_three,
  output logic [7:0]             slot_four,
  output logic [7:0]             slot_five,
  output logic                   last
);

  hsk_pkg::op_t   op;
  logic [7:0]     code;
  logic [CNT_W-1:0] cnt;
  hsk_pkg::kind_t kind_reg;
  logic [7:0]     mod_state;
  logic [7:0]     key_slots [hsk_pkg::NUM_SLOTS];

  logic [7:0]     mod_next;
  logic [7:0]     slots_next [hsk_pkg::NUM_SLOTS];
  logic [6:0]     raw;
  logic [6:0]     mag;
  logic [6:0]     mag_sat;
  logic [CNT_W-1:0] cnt_load;
  hsk_pkg::kind_t kind_load;
  logic           is_key;
  logic           is_press;
  logic           with_keys;

  // Step count: magnitude of the signed delta, saturated at MAX_STEPS, for volume; one otherwise.
  always_comb begin
    raw     = volume_delta;
    mag     = raw[6] ? (~raw + 7'd1) : raw;
    mag_sat = (mag > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : mag;
    if (cmd == hsk_pkg::OP_VOLUME) begin
      cnt_load  = CNT_W'(mag_sat);
      kind_load = raw[6] ? hsk_pkg::KIND_VOL_DOWN : hsk_pkg::KIND_VOL_UP;
    end else if (cmd == hsk_pkg::OP_MUTE) begin
      cnt_load  = CNT_W'(1);
      kind_load = hsk_pkg::KIND_MUTE;
    end else begin
      cnt_load  = CNT_W'(1);
      kind_load = hsk_pkg::KIND_REPORT;
    end
  end

  // Report update: modifier bit, or first matching slot.
  always_comb begin
    logic       found;
    logic [7:0] want;
    found    = 1'b0;
    is_press = (op == hsk_pkg::OP_PRESS);
    is_key   = (op == hsk_pkg::OP_PRESS) || (op == hsk_pkg::OP_RELEASE);
    want     = is_press ? 8'h00 : code;
    mod_next = mod_state;
    for (int i = 0; i < hsk_pkg::NUM_SLOTS; i++) begin
      slots_next[i] = key_slots[i];
    end
    if (code[7:3] == hsk_pkg::MOD_PREFIX) begin
      if (is_press) begin
        mod_next = mod_state | (8'd1 << code[2:0]);
      end else begin
        mod_next = mod_state & ~(8'd1 << code[2:0]);
      end
    end else begin
      for (int i = 0; i < hsk_pkg::NUM_SLOTS; i++) begin
        if (!found && key_slots[i] == want) begin
          slots_next[i] = is_press ? code : 8'h00;
          found         = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_in.load) begin
      op       <= cmd;
      code     <= key_code;
      kind_reg <= kind_load;
    end
    if (cmd_in.load) begin
      cnt <= cnt_load;
    end else if (cmd_in.step) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_state <= '0;
      for (int i = 0; i < hsk_pkg::NUM_SLOTS; i++) begin
        key_slots[i] <= '0;
      end
    end else if (cmd_in.apply && is_key) begin
      mod_state <= mod_next;
      for (int i = 0; i < hsk_pkg::NUM_SLOTS; i++) begin
        key_slots[i] <= slots_next[i];
      end
    end
  end

  assign status.cnt_zero = (cnt == '0);
  assign status.cnt_one  = (cnt == CNT_W'(1));

  assign with_keys     = (kind_reg == hsk_pkg::KIND_REPORT);
  assign kind          = kind_reg;
  assign modifier_bits = with_keys ? mod_state : 8'h00;
  assign slot_zero     = with_keys ? key_slots[0] : 8'h00;
  assign slot_one      = with_keys ? key_slots[1] : 8'h00;
  assign slot_two      = with_keys ? key_slots[2] : 8'h00;
  assign slot_three    = with_keys ? key_slots[3] : 8'h00;
  assign slot_four     = with_keys ? key_slots[4] : 8'h00;
  assign slot_five     = with_keys ? key_slots[5] : 8'h00;
  assign last          = status.cnt_one;

endmodule
`default_nettype wire

// File: src/hid_six_key_report_builder_core.sv
// A word accepted in idle passes the apply state before its first result shows.
// A key or mute word sends one result and a new word is taken only in idle; a volume
// word sends N results, N its saturated step count (none when N is 0), one result per cycle.
// The step counter in the datapath sets the volume burst length.
// Reset clears the modifier byte, empties all six key slots and returns to idle.
// Results are one-cycle strobes; the receiver cannot hold them off.
`default_nettype none
module hid_six_key_report_builder_core #(
  parameter int MAX_VOLUME_STEPS = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd,
  input  logic [7:0]        key_code,
  input  logic signed [6:0] volume_delta,
  output logic              strobe,
  output logic [1:0]        kind,
  output logic [7:0]        modifier_bits,
  output logic [7:0]        slot_zero,
  output logic [7:0]        slot_one,
  output logic [7:0]        slot_two,
  output logic [7:0]        slot_three,
  output logic [7:0]        slot_four,
  output logic [7:0]        slot_five,
  output logic              last
);

  // Counter must hold the step limit itself.
  localparam int CNT_W = $clog2(MAX_VOLUME_STEPS + 1);

  hsk_pkg::ctrl_cmd_t  ctrl_cmd;
  hsk_pkg::dp_status_t dp_status;

  // Sequence each word: capture, update the report, then send its results.
  hsk_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .status  (dp_status),
    .cmd_out (ctrl_cmd),
    .busy    (busy),
    .strobe  (strobe)
  );

  // Hold the report state and count down the volume burst.
  hsk_dp #(
    .MAX_STEPS (MAX_VOLUME_STEPS),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd_in        (ctrl_cmd),
    .cmd           (cmd),
    .key_code      (key_code),
    .volume_delta  (volume_delta),
    .status        (dp_status),
    .kind          (kind),
    .modifier_bits (modifier_bits),
    .slot_zero     (slot_zero),
    .slot_one      (slot_one),
    .slot_two      (slot_two),
    .slot_three    (slot_three),
    .slot_four     (slot_four),
    .slot_five     (slot_five),
    .last          (last)
  );

endmodule
`default_nettype wire

// File: src/hsk_checker.sv
// Port-level checker for the six-key HID report builder, bound to the top level.
`default_nettype none
`include "hid_six_key_report_builder_core_assert.svh"
module hsk_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [1:0]        kind,
  input logic [7:0]        modifier_bits,
  input logic [7:0]        slot_zero,
  input logic              last
);

  logic consumer_word;
  logic key_bits_zero;

  assign consumer_word = strobe && (kind != hsk_pkg::KIND_REPORT);
  assign key_bits_zero = (modifier_bits == 8'h00) && (slot_zero == 8'h00);

  `HSK_ASSERT_NOW(a_strobe_busy, strobe, busy, "result outside a busy period")
  `HSK_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `HSK_ASSERT_NEXT(a_last_ends, strobe && last, !strobe, "result after the final one")
  `HSK_ASSERT_NEXT(a_burst_cont, strobe && !last, strobe, "volume burst broke off early")
  `HSK_ASSERT_NOW(a_blank_fields, consumer_word, key_bits_zero, "key fields on consumer event")

endmodule

bind hid_six_key_report_builder_core hsk_checker u_hsk_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .strobe        (strobe),
  .kind          (kind),
  .modifier_bits (modifier_bits),
  .slot_zero     (slot_zero),
  .last          (last)
);
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the six-key HID report builder core.
`default_nettype none
module tb_top;

  localparam int VOLUME_CAP  = 63;    // saturation of the volume burst length
  localparam int STALL_LIMIT = 2000;  // cycles without an accepted word or a result before giving up
  localparam int TAIL_CYCLES = 16;    // settle time after the last report

  // One command word as queued for the driver.
  typedef struct packed {
    hsk_pkg::op_t      op;
    logic [7:0]        code;
    logic signed [6:0] delta;
    logic              drain;  // wait until every report is back before offering
  } event_word_t;

  // One expected result word.
  typedef struct packed {
    hsk_pkg::kind_t  kind;
    logic [7:0]      mods;
    logic [5:0][7:0] keys;
    logic            last;
  } report_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        cmd = '0;
  logic [7:0]        key_code = '0;
  logic signed [6:0] volume_delta = '0;
  logic              strobe;
  logic [1:0]        kind;
  logic [7:0]        modifier_bits;
  logic [7:0]        slot_zero;
  logic [7:0]        slot_one;
  logic [7:0]        slot_two;
  logic [7:0]        slot_three;
  logic [7:0]        slot_four;
  logic [7:0]        slot_five;
  logic              last;

  event_word_t  event_words[$];
  report_word_t pending_reports[$];

  // Shadow copy of the report state.
  logic [7:0] mod_byte;
  logic [7:0] held_keys [hsk_pkg::NUM_SLOTS];

  int  words_taken = 0;
  int  stall_cycles = 0;
  bit  failed = 1'b0;

  hid_six_key_report_builder_core #(
    .MAX_VOLUME_STEPS(VOLUME_CAP)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .key_code     (key_code),
    .volume_delta (volume_delta),
    .strobe       (strobe),
    .kind         (kind),
    .modifier_bits(modifier_bits),
    .slot_zero    (slot_zero),
    .slot_one     (slot_one),
    .slot_two     (slot_two),
    .slot_three   (slot_three),
    .slot_four    (slot_four),
    .slot_five    (slot_five),
    .last         (last)
  );

  always #5 clk = ~clk;

  // Queue a command word for the driver.
  task automatic add_word(input hsk_pkg::op_t op, input logic [7:0] code,
                          input logic signed [6:0] delta, input logic drain);
    event_word_t w;
    w.op    = op;
    w.code  = code;
    w.delta = delta;
    w.drain = drain;
    event_words.push_back(w);
  endtask

  // Mostly a small pool of keys so that releases hit held keys and the
  // slots fill up; some modifier codes; now and then any code at all.
  function automatic logic [7:0] pick_code();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6)
      return 8'h04 + 8'($urandom_range(7));
    else if (sel < 8)
      return 8'hE0 + 8'($urandom_range(7));
    else
      return 8'($urandom_range(255));
  endfunction

  // Advance the shadow state by one accepted word and queue the reports
  // that it must produce.
  task automatic predict_reports(input hsk_pkg::op_t op, input logic [7:0] code,
                                 input logic signed [6:0] delta);
    report_word_t r;
    int           steps;
    logic [7:0]   match_code;
    logic [7:0]   fill_code;
    r = '0;
    case (op)
      hsk_pkg::OP_VOLUME: begin
        // Negate in a wider type so -64 becomes 64 before the cap.
        steps = (delta < 0) ? -int'(delta) : int'(delta);
        if (steps > VOLUME_CAP)
          steps = VOLUME_CAP;
        r.kind = (delta < 0) ? hsk_pkg::KIND_VOL_DOWN : hsk_pkg::KIND_VOL_UP;
        for (int n = 0; n < steps; n++) begin
          r.last = (n == steps - 1);
          pending_reports.push_back(r);
        end
      end
      hsk_pkg::OP_MUTE: begin
        r.kind = hsk_pkg::KIND_MUTE;
        r.last = 1'b1;
        pending_reports.push_back(r);
      end
      default: begin
        if (code[7:3] == hsk_pkg::MOD_PREFIX) begin
          if (op == hsk_pkg::OP_PRESS)
            mod_byte[code[2:0]] = 1'b1;
          else
            mod_byte[code[2:0]] = 1'b0;
        end else begin
          // A press looks for an empty slot, a release for the code itself.
          match_code = (op == hsk_pkg::OP_PRESS) ? 8'h00 : code;
          fill_code  = (op == hsk_pkg::OP_PRESS) ? code : 8'h00;
          for (int s = 0; s < hsk_pkg::NUM_SLOTS; s++) begin
            if (held_keys[s] == match_code) begin
              held_keys[s] = fill_code;
              break;
            end
          end
        end
        r.kind = hsk_pkg::KIND_REPORT;
        r.mods = mod_byte;
        for (int s = 0; s < hsk_pkg::NUM_SLOTS; s++)
          r.keys[s] = held_keys[s];
        r.last = 1'b1;
        pending_reports.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Driver: present the head of the event queue, hold it until the block
  // takes it, and idle at the rate of the current phase. Drive noise on the
  // fields while start is low so the block must ignore them.
  always @(posedge clk) begin : drive_words
    int idle_pct;
    idle_pct = (words_taken < 100) ? 10 : (words_taken < 200) ? 65 : 0;
    if (rst) begin
      start        <= 1'b0;
      mod_byte     = '0;
      for (int s = 0; s < hsk_pkg::NUM_SLOTS; s++)
        held_keys[s] = '0;
    end else begin
      if (start && !busy) begin
        predict_reports(hsk_pkg::op_t'(cmd), key_code, volume_delta);
        void'(event_words.pop_front());
        words_taken++;
      end
      if (start && busy) begin
        // hold the word until the block is free
      end else if (event_words.size() != 0
                   && !(event_words[0].drain && pending_reports.size() != 0)
                   && $urandom_range(99) >= idle_pct) begin
        start        <= 1'b1;
        cmd          <= event_words[0].op;
        key_code     <= event_words[0].code;
        volume_delta <= event_words[0].delta;
      end else begin
        start        <= 1'b0;
        cmd          <= 2'($urandom);
        key_code     <= 8'($urandom);
        volume_delta <= 7'($urandom);
      end
    end
  end

  // Monitor: every strobe must match the oldest expected report.
  always @(posedge clk) begin : watch_reports
    report_word_t want;
    if (!rst && strobe) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d last %0b",
                 $time, kind, last);
        failed = 1'b1;
      end else begin
        want = pending_reports.pop_front();
        check_field("kind",          want.kind,    kind);
        check_field("modifier_bits", want.mods,    modifier_bits);
        check_field("slot_zero",     want.keys[0], slot_zero);
        check_field("slot_one",      want.keys[1], slot_one);
        check_field("slot_two",      want.keys[2], slot_two);
        check_field("slot_three",    want.keys[3], slot_three);
        check_field("slot_four",     want.keys[4], slot_four);
        check_field("slot_five",     want.keys[5], slot_five);
        check_field("last",          want.last,    last);
      end
    end
  end

  // Watchdog: give up when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // Directed words: modifier edges, code zero, repeated press, full slots,
    // released and absent keys, mute, and every volume corner.
    add_word(hsk_pkg::OP_PRESS,   8'hE0, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_PRESS,   8'hE7, -7'sd1,  1'b0);
    add_word(hsk_pkg::OP_RELEASE, 8'hE0, 7'sd63,  1'b0);
    add_word(hsk_pkg::OP_PRESS,   8'h00, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_RELEASE, 8'h00, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_PRESS,   8'h04, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_PRESS,   8'h04, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_PRESS,   8'h05, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_PRESS,   8'hFF, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_PRESS,   8'hDF, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_PRESS,   8'hE8, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_PRESS,   8'h07, 7'sd0,   1'b0);  // all six slots taken: drop
    add_word(hsk_pkg::OP_RELEASE, 8'h04, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_RELEASE, 8'h99, 7'sd0,   1'b0);  // not held
    add_word(hsk_pkg::OP_RELEASE, 8'h00, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_MUTE,    8'hFF, -7'sd64, 1'b1);  // pause until drained
    add_word(hsk_pkg::OP_VOLUME,  8'hFF, 7'sd0,   1'b0);
    add_word(hsk_pkg::OP_VOLUME,  8'h00, 7'sd1,   1'b0);
    add_word(hsk_pkg::OP_VOLUME,  8'h00, -7'sd1,  1'b0);
    add_word(hsk_pkg::OP_VOLUME,  8'hE3, 7'sd63,  1'b0);
    add_word(hsk_pkg::OP_VOLUME,  8'h00, -7'sd63, 1'b0);
    add_word(hsk_pkg::OP_VOLUME,  8'h00, -7'sd64, 1'b1);
    add_word(hsk_pkg::OP_RELEASE, 8'hE7, 7'sd0,   1'b0);

    // Random words: mostly key traffic on a small pool, some mute and volume.
    for (int i = 0; i < 300; i++) begin : fill_random
      int sel;
      logic signed [6:0] delta;
      sel = $urandom_range(99);
      if ($urandom_range(3) == 0)
        delta = 7'($urandom);
      else
        delta = 7'($urandom_range(16) - 8);
      if (sel < 42)
        add_word(hsk_pkg::OP_PRESS, pick_code(), delta, $urandom_range(39) == 0);
      else if (sel < 80)
        add_word(hsk_pkg::OP_RELEASE, pick_code(), delta, $urandom_range(39) == 0);
      else if (sel < 88)
        add_word(hsk_pkg::OP_MUTE, 8'($urandom), delta, $urandom_range(39) == 0);
      else
        add_word(hsk_pkg::OP_VOLUME, 8'($urandom), delta, $urandom_range(39) == 0);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Drain: wait for every word to be taken and every report to come back.
    while (event_words.size() != 0 || start || pending_reports.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_reports.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_reports.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
+incdir+src
src/hsk_pkg.sv
src/hsk_ctrl.sv
src/hsk_dp.sv
src/hid_six_key_report_builder_core.sv
src/hsk_checker.sv
bench/tb_top.sv
